[hw/rtl/stlc_pkg.sv]
`default_nettype none

package stlc_pkg;

    // Default counter width for the step timer and the off-hold counter
    localparam int TIMER_BITS_DEF = 16;

    // Configuration registers
    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 2;

    typedef logic [CFG_WIDTH-1:0]     t_cfg_word;
    typedef logic [CFG_IDX_WIDTH-1:0] t_cfg_index;

    localparam t_cfg_index REG_NORMAL_STEP = 2'd0;
    localparam t_cfg_index REG_TEST_STEP   = 2'd1;
    localparam t_cfg_index REG_OFF_HOLD    = 2'd2;

    localparam t_cfg_word NORMAL_STEP_RESET = 16'd100;
    localparam t_cfg_word TEST_STEP_RESET   = 16'd10;
    localparam t_cfg_word OFF_HOLD_RESET    = 16'd60;

    // Debounced pin vector
    localparam int PIN_COUNT = 5;
    typedef logic [PIN_COUNT-1:0] t_pins;

    localparam int PIN_TURN  = 0;
    localparam int PIN_DRL   = 1;
    localparam int PIN_POS   = 2;
    localparam int PIN_WHITE = 3;
    localparam int PIN_TEST  = 4;

    // Lamps
    localparam int LAMP_COUNT = 10;
    typedef logic [LAMP_COUNT-1:0] t_lamps;

    localparam t_lamps LAMPS_NONE   = 10'h000;
    localparam t_lamps LAMPS_ALL    = 10'h3FF;
    localparam t_lamps LAMPS_GROUP1 = 10'h023;
    localparam t_lamps LAMPS_GROUP2 = 10'h04C;
    localparam t_lamps LAMPS_GROUP3 = 10'h190;
    localparam t_lamps LAMPS_GROUP4 = 10'h200;

    typedef logic [1:0] t_duty;

    localparam t_duty DUTY_FULL = 2'd0;
    localparam t_duty DUTY_DRL  = 2'd1;
    localparam t_duty DUTY_POS  = 2'd2;

    typedef logic [2:0] t_seq;

    localparam t_seq SEQ_IDLE   = 3'd0;
    localparam t_seq SEQ_GROUP1 = 3'd1;
    localparam t_seq SEQ_GROUP2 = 3'd2;
    localparam t_seq SEQ_GROUP3 = 3'd3;
    localparam t_seq SEQ_DONE   = 3'd4;

    typedef struct packed {
        t_lamps yellow_lamps;
        logic   white_lamp;
        t_duty  duty_code;
        logic   side_light;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/stlc_in_if.sv]
`default_nettype none

interface stlc_in_if;
    logic valid;
    logic ready;
    logic tick_elapsed;
    logic raw_turn;
    logic raw_drl;
    logic raw_position;
    logic raw_white_select;
    logic raw_test;

    modport source (
        output valid, tick_elapsed, raw_turn, raw_drl, raw_position,
               raw_white_select, raw_test,
        input  ready
    );

    modport sink (
        input  valid, tick_elapsed, raw_turn, raw_drl, raw_position,
               raw_white_select, raw_test,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/stlc_out_if.sv]
`default_nettype none

interface stlc_out_if;
    logic                  valid;
    logic                  ready;
    stlc_pkg::t_lamps      yellow_lamps;
    logic                  white_lamp;
    stlc_pkg::t_duty       duty_code;
    logic                  side_light;

    modport source (
        output valid, yellow_lamps, white_lamp, duty_code, side_light,
        input  ready
    );

    modport sink (
        input  valid, yellow_lamps, white_lamp, duty_code, side_light,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/sequential_turn_lamp_controller.sv]
// Sequential turn lamp controller.
// Input channel i_in: one beat per evaluation, carrying the raw pin levels
// and a tick flag. On a tick the pins are debounced, the step timer advances and
// the off-hold counter advances while turn is off (both saturating). Every beat runs the lamp sequencer
// and the DRL / position selection and yields exactly one result beat on
// o_out: ten yellow lamp bits, the white lamp, a duty code and the side light.
// The result is registered in the output register, or in the skid while a result waits.
// Throughput: one beat per cycle while the skid is empty; the whole update is one pass of logic
// between the state registers and the result register.
// A two-entry result buffer (output register plus skid) lets the block take
// one more beat while a result waits; i_in.ready drops only when both are
// full, and picks up again the cycle after o_out.ready returns.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 normal step ticks, 1 test step ticks, 2 off hold ticks); other
// indexes are ignored. Write only while idle.
// Reset (i_rst_n low, synchronous): all lamps off, sequencer idle, registers
// back to 100 / 10 / 60 ticks, result buffer empty.
`default_nettype none

module sequential_turn_lamp_controller #(
    parameter int TIMER_BITS = stlc_pkg::TIMER_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    stlc_in_if.sink                i_in,
    stlc_out_if.source             o_out,
    input  wire                    i_cfg_we,
    input  wire stlc_pkg::t_cfg_index i_cfg_index,
    input  wire stlc_pkg::t_cfg_word  i_cfg_data
);

    localparam int CW = (TIMER_BITS > stlc_pkg::CFG_WIDTH) ? TIMER_BITS
                                                           : stlc_pkg::CFG_WIDTH;

    typedef logic [TIMER_BITS-1:0] t_timer;

    // configuration
    stlc_pkg::t_cfg_word r_normal_step;
    stlc_pkg::t_cfg_word r_test_step;
    stlc_pkg::t_cfg_word r_off_hold;

    // block state
    stlc_pkg::t_pins     r_prev,     n_prev;
    stlc_pkg::t_pins     r_stable,   n_stable;
    t_timer              r_off_cnt,  n_off_cnt;
    logic                r_off_long, n_off_long;
    t_timer              r_timer,    n_timer;
    stlc_pkg::t_cfg_word r_delay,    n_delay;
    stlc_pkg::t_seq      r_seq,      n_seq;
    logic                r_handled,  n_handled;
    stlc_pkg::t_lamps    r_yellow,   n_yellow;
    logic                r_white,    n_white;
    stlc_pkg::t_duty     r_duty,     n_duty;
    logic                r_side,     n_side;

    // result buffer
    logic                r_out_valid;
    logic                r_skid_valid;
    stlc_pkg::t_result   r_out;
    stlc_pkg::t_result   r_skid;

    stlc_pkg::t_pins     sample;
    stlc_pkg::t_result   result;
    logic                push;
    logic                pop;
    logic                turn;

    assign i_in.ready = !r_skid_valid;
    assign push       = i_in.valid && !r_skid_valid;
    assign pop        = r_out_valid && o_out.ready;

    assign sample = {i_in.raw_test, i_in.raw_white_select, i_in.raw_position,
                     i_in.raw_drl, i_in.raw_turn};

    always_comb begin
        n_prev     = r_prev;
        n_stable   = r_stable;
        n_off_cnt  = r_off_cnt;
        n_off_long = r_off_long;
        n_timer    = r_timer;
        n_delay    = r_delay;
        n_seq      = r_seq;
        n_handled  = r_handled;
        n_yellow   = r_yellow;
        n_white    = r_white;
        n_duty     = r_duty;
        n_side     = r_side;

        if (i_in.tick_elapsed) begin
            n_timer = (&r_timer) ? r_timer : r_timer + TIMER_BITS'(1);
            // a sample is taken as stable only when it repeats
            if (sample != r_prev) begin
                n_prev = sample;
            end else begin
                n_stable = sample;
            end

            if (!n_stable[stlc_pkg::PIN_TURN]) begin
                n_off_cnt = (&r_off_cnt) ? r_off_cnt : r_off_cnt + TIMER_BITS'(1);
                if (CW'(n_off_cnt) >= CW'(r_off_hold)) begin
                    n_off_long = 1'b1;
                    n_off_cnt  = TIMER_BITS'(r_off_hold);
                end
            end else begin
                n_off_cnt  = '0;
                n_off_long = 1'b0;
                n_handled  = 1'b0;
            end

            n_delay = n_stable[stlc_pkg::PIN_TEST] ? r_test_step : r_normal_step;
            n_side  = n_stable[stlc_pkg::PIN_POS];
        end

        turn = n_stable[stlc_pkg::PIN_TURN];
        if (!turn) begin
            n_seq = stlc_pkg::SEQ_IDLE;
            if (!n_handled) begin
                n_handled = 1'b1;
                n_yellow  = stlc_pkg::LAMPS_NONE;
                n_white   = 1'b0;
                n_duty    = stlc_pkg::DUTY_FULL;
            end
        end

        unique case (n_seq)
            stlc_pkg::SEQ_IDLE: begin
                if (turn) begin
                    n_yellow = stlc_pkg::LAMPS_GROUP1;
                    n_white  = 1'b0;
                    n_duty   = stlc_pkg::DUTY_FULL;
                    n_seq    = stlc_pkg::SEQ_GROUP1;
                    n_timer  = '0;
                end
            end
            stlc_pkg::SEQ_GROUP1, stlc_pkg::SEQ_GROUP2, stlc_pkg::SEQ_GROUP3: begin
                if (CW'(n_timer) >= CW'(n_delay)) begin
                    unique case (n_seq)
                        stlc_pkg::SEQ_GROUP1: n_yellow = n_yellow | stlc_pkg::LAMPS_GROUP2;
                        stlc_pkg::SEQ_GROUP2: n_yellow = n_yellow | stlc_pkg::LAMPS_GROUP3;
                        default:              n_yellow = n_yellow | stlc_pkg::LAMPS_GROUP4;
                    endcase
                    n_seq   = n_seq + 3'd1;
                    n_timer = '0;
                end
            end
            stlc_pkg::SEQ_DONE: begin
            end
            default: begin
                // unused step codes fall back to idle
                n_seq   = stlc_pkg::SEQ_IDLE;
                n_timer = '0;
            end
        endcase

        if (n_off_long) begin
            if (n_stable[stlc_pkg::PIN_DRL] || n_stable[stlc_pkg::PIN_POS]) begin
                n_duty = n_stable[stlc_pkg::PIN_DRL] ? stlc_pkg::DUTY_DRL
                                                     : stlc_pkg::DUTY_POS;
                if (n_stable[stlc_pkg::PIN_WHITE]) begin
                    n_yellow = stlc_pkg::LAMPS_NONE;
                    n_white  = 1'b1;
                end else begin
                    n_yellow = stlc_pkg::LAMPS_ALL;
                    n_white  = 1'b0;
                end
            end else begin
                n_yellow = stlc_pkg::LAMPS_NONE;
                n_white  = 1'b0;
                n_duty   = stlc_pkg::DUTY_FULL;
            end
        end

        result.yellow_lamps = n_yellow;
        result.white_lamp   = n_white;
        result.duty_code    = n_duty;
        result.side_light   = n_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal_step <= stlc_pkg::NORMAL_STEP_RESET;
            r_test_step   <= stlc_pkg::TEST_STEP_RESET;
            r_off_hold    <= stlc_pkg::OFF_HOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                stlc_pkg::REG_NORMAL_STEP: r_normal_step <= i_cfg_data;
                stlc_pkg::REG_TEST_STEP:   r_test_step   <= i_cfg_data;
                stlc_pkg::REG_OFF_HOLD:    r_off_hold    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_stable   <= '0;
            r_off_cnt  <= '0;
            r_off_long <= 1'b0;
            r_timer    <= '0;
            r_delay    <= stlc_pkg::NORMAL_STEP_RESET;
            r_seq      <= stlc_pkg::SEQ_IDLE;
            r_handled  <= 1'b0;
            r_yellow   <= stlc_pkg::LAMPS_NONE;
            r_white    <= 1'b0;
            r_duty     <= stlc_pkg::DUTY_FULL;
            r_side     <= 1'b0;
        end else if (push) begin
            r_prev     <= n_prev;
            r_stable   <= n_stable;
            r_off_cnt  <= n_off_cnt;
            r_off_long <= n_off_long;
            r_timer    <= n_timer;
            r_delay    <= n_delay;
            r_seq      <= n_seq;
            r_handled  <= n_handled;
            r_yellow   <= n_yellow;
            r_white    <= n_white;
            r_duty     <= n_duty;
            r_side     <= n_side;
        end
    end

    // two-entry result buffer; skid only fills while the output beat waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= push;
            end
        end else if (push) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_skid_valid) begin
            r_out <= r_skid;
        end else if (push && (pop || !r_out_valid)) begin
            r_out <= result;
        end
        if (push && r_out_valid && !pop) begin
            r_skid <= result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.yellow_lamps = r_out.yellow_lamps;
    assign o_out.white_lamp   = r_out.white_lamp;
    assign o_out.duty_code    = r_out.duty_code;
    assign o_out.side_light   = r_out.side_light;

endmodule

`default_nettype wire
